[src/cte_pkg.sv]
// ----------------------------------------------------------------------------
// Column threshold edge finder: shared package
// Field widths, register map, default depth and the divider request word.
// ----------------------------------------------------------------------------
package cte_pkg;

	// Default column buffer depth in samples.
	localparam int MAX_ROWS_DEF = 1024;

	// Payload field widths.
	localparam int PIX_W  = 8;
	localparam int COL_W  = 12;
	localparam int OFS_W  = 12;
	localparam int ROW_W  = 10;
	localparam int FRAC_W = 8;

	// Threshold in 1/16 units, signed: covers -4095 .. 4080.
	localparam int THR_W = 14;

	// Divider operands: numerator and denominator in 1/16 units.
	localparam int NUM_W = 12;

	// Samples in the qualifying window: outside pixel plus three inside.
	localparam int WIN_LEN = 4;

	// Register map.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_BRIGHTNESS_OFFSET = 3'd0;

	// Request word handed to the fraction divider.
	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] den;
	} div_req_t;

endpackage

[src/cte_store.sv]
// ----------------------------------------------------------------------------
// Column sample store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module cte_store #(
	parameter int DEPTH = cte_pkg::MAX_ROWS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [AW-1:0]            wr_addr,
	input  logic [cte_pkg::PIX_W-1:0] wr_data,
	input  logic [AW-1:0]            rd_addr,
	output logic [cte_pkg::PIX_W-1:0] rd_data_q
);

	logic [cte_pkg::PIX_W-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

[src/cte_div.sv]
// ----------------------------------------------------------------------------
// Fraction divider
// Restoring division giving floor(num * 256 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cte_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  cte_pkg::div_req_t         req,
	output logic                      done_q,
	output logic [cte_pkg::FRAC_W-1:0] quo_q
);

	localparam int RW = cte_pkg::NUM_W + 1;
	localparam int CNT_W = $clog2(cte_pkg::FRAC_W + 1);

	logic [RW-1:0]               rem_q;
	logic [cte_pkg::NUM_W-1:0]   den_q;
	logic [CNT_W-1:0]            cnt_q;
	logic                        run_q;
	logic [RW-1:0]               rem_sh;
	logic                        take;

	// The numerator is always below the denominator, so the remainder
	// fits in NUM_W bits and its doubled value in one more.
	always_comb begin
		rem_sh = {rem_q[RW-2:0], 1'b0};
		take   = rem_sh >= {1'b0, den_q};
	end

	// Iteration control and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				rem_q <= {1'b0, req.num};
				den_q <= req.den;
			end else if (run_q) begin
				rem_q <= take ? (rem_sh - {1'b0, den_q}) : rem_sh;
				quo_q <= {quo_q[cte_pkg::FRAC_W-2:0], take};
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(cte_pkg::FRAC_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[src/column_threshold_edge_finder.sv]
// ----------------------------------------------------------------------------
// Column threshold edge finder
// A sample not marked last is taken while idle; busy stays low. The last
// sample of a column starts a bottom-up scan of the store; the result is
// registered when the scan ends with no crossing, or when the divider is
// done if one is found. Throughput: one sample a cycle while loading; the
// scan reads one store entry a cycle. Reset clears control and the offset
// register, not the store. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module column_threshold_edge_finder #(
	parameter int MAX_ROWS = cte_pkg::MAX_ROWS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Sample channel.
	input  logic                              start,
	output logic                              busy,
	input  logic [cte_pkg::PIX_W-1:0]         brightness,
	input  logic [cte_pkg::COL_W-1:0]         column_number,
	input  logic                              last_sample,
	// Result channel.
	output logic                              result_valid,
	output logic [cte_pkg::COL_W-1:0]         result_column,
	output logic                              found,
	output logic [cte_pkg::ROW_W-1:0]         edge_row,
	output logic [cte_pkg::FRAC_W-1:0]        edge_fraction,
	output logic [cte_pkg::PIX_W-1:0]         column_max,
	output logic                              overflow,
	// Configuration port.
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [cte_pkg::PADDR_W-1:0]       paddr,
	input  logic [cte_pkg::PDATA_W-1:0]       pwdata,
	output logic [cte_pkg::PDATA_W-1:0]       prdata,
	output logic                              pready
);

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_ROWS + 1);
	localparam int RW = (AW > cte_pkg::ROW_W) ? AW : cte_pkg::ROW_W;
	localparam int PW = cte_pkg::PIX_W;
	localparam int TW = cte_pkg::THR_W;
	localparam int FW = $clog2(cte_pkg::WIN_LEN + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV
	} state_t;

	state_t                   state_q;
	logic [cte_pkg::OFS_W-1:0] offset_q;

	// Column accumulation.
	logic [CW-1:0]            count_q;
	logic [PW-1:0]            max_q;
	logic                     ovf_q;

	// Scan state.
	logic signed [TW-1:0]     thr_q;
	logic [PW-1:0]            colmax_q;
	logic                     colovf_q;
	logic [cte_pkg::COL_W-1:0] col_q;
	logic [AW-1:0]            rd_addr_q;
	logic [CW-1:0]            rd_left_q;
	logic                     rd_valid_s1;
	logic [AW-1:0]            rd_idx_s1;
	logic [PW-1:0]            win_q [cte_pkg::WIN_LEN];
	logic [AW-1:0]            widx_q;
	logic [FW-1:0]            fill_q;
	logic [cte_pkg::ROW_W-1:0] row_q;

	// Combinational helpers.
	logic                     accept;
	logic                     cfg_wr;
	logic                     store_wr;
	logic [CW-1:0]            cnt_nxt;
	logic [CW-1:0]            cnt_m1;
	logic [PW-1:0]            max_nxt;
	logic [PW-1:0]            rd_data;
	logic                     issue;
	logic signed [TW-1:0]     v16 [cte_pkg::WIN_LEN];
	logic                     match_c;
	logic [RW-1:0]            row_wide;
	logic signed [TW-1:0]     num_wide;
	logic [PW-1:0]            pix_diff;
	cte_pkg::div_req_t        div_req;
	logic                     div_start;
	logic                     div_done;
	logic [cte_pkg::FRAC_W-1:0] div_quo;

	// Handshake and configuration decode.
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr == cte_pkg::ADDR_BRIGHTNESS_OFFSET) begin
			prdata = {{(cte_pkg::PDATA_W - cte_pkg::OFS_W){1'b0}}, offset_q};
		end
	end

	// Sample store update: write while room is left, track the maximum.
	always_comb begin
		store_wr = accept && (count_q < CW'(MAX_ROWS));
		cnt_nxt  = store_wr ? (count_q + CW'(1)) : count_q;
		cnt_m1   = cnt_nxt - CW'(1);
		max_nxt  = (store_wr && (brightness > max_q)) ? brightness : max_q;
	end

	cte_store #(
		.DEPTH (MAX_ROWS),
		.AW    (AW)
	) u_store (
		.clk       (clk),
		.wr_en     (store_wr),
		.wr_addr   (count_q[AW-1:0]),
		.wr_data   (brightness),
		.rd_addr   (rd_addr_q),
		.rd_data_q (rd_data)
	);

	// Window check: win_q[0] is the highest sample read so far (lowest
	// row), win_q[3] the lowest; win_q[3] is the outside pixel.
	always_comb begin
		for (int i = 0; i < cte_pkg::WIN_LEN; i++) begin
			v16[i] = $signed({2'b00, win_q[i], 4'b0000});
		end
		match_c = (fill_q == FW'(cte_pkg::WIN_LEN)) && (v16[3] < thr_q) &&
			(v16[2] >= thr_q) && (v16[1] >= thr_q) && (v16[0] >= thr_q);
		row_wide = RW'(widx_q) + RW'(2);
		num_wide = v16[2] - thr_q;
		pix_diff = win_q[2] - win_q[3];
		div_req.num = num_wide[cte_pkg::NUM_W-1:0];
		div_req.den = {pix_diff, 4'b0000};
		issue     = (rd_left_q != '0);
		div_start = (state_q == ST_SCAN) && match_c;
	end

	cte_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.done_q (div_done),
		.quo_q  (div_quo)
	);

	// Offset register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (cfg_wr && (paddr == cte_pkg::ADDR_BRIGHTNESS_OFFSET)) begin
			offset_q <= pwdata[cte_pkg::OFS_W-1:0];
		end
	end

	// Sequencer: load, scan, divide, and registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			max_q        <= '0;
			ovf_q        <= 1'b0;
			rd_left_q    <= '0;
			rd_valid_s1  <= 1'b0;
			fill_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			rd_valid_s1  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (last_sample) begin
							thr_q     <= $signed({2'b00, max_nxt, 4'b0000}) -
								$signed({2'b00, offset_q});
							colmax_q  <= max_nxt;
							colovf_q  <= ovf_q || !store_wr;
							col_q     <= column_number;
							rd_addr_q <= cnt_m1[AW-1:0];
							rd_left_q <= cnt_nxt;
							fill_q    <= '0;
							count_q   <= '0;
							max_q     <= '0;
							ovf_q     <= 1'b0;
							state_q   <= ST_SCAN;
						end else begin
							count_q <= cnt_nxt;
							max_q   <= max_nxt;
							ovf_q   <= ovf_q || !store_wr;
						end
					end
				end
				ST_SCAN: begin
					if (match_c) begin
						row_q   <= row_wide[cte_pkg::ROW_W-1:0];
						state_q <= ST_DIV;
					end else if (!issue && !rd_valid_s1) begin
						result_valid  <= 1'b1;
						result_column <= col_q;
						found         <= 1'b0;
						edge_row      <= '0;
						edge_fraction <= '0;
						column_max    <= colmax_q;
						overflow      <= colovf_q;
						state_q       <= ST_IDLE;
					end else if (issue) begin
						rd_valid_s1 <= 1'b1;
						rd_idx_s1   <= rd_addr_q;
						rd_addr_q   <= rd_addr_q - AW'(1);
						rd_left_q   <= rd_left_q - CW'(1);
					end
					// Shift returning read data into the window.
					if (rd_valid_s1) begin
						win_q[0] <= rd_data;
						for (int i = 1; i < cte_pkg::WIN_LEN; i++) begin
							win_q[i] <= win_q[i-1];
						end
						widx_q <= rd_idx_s1;
						if (fill_q != FW'(cte_pkg::WIN_LEN)) begin
							fill_q <= fill_q + FW'(1);
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						result_valid  <= 1'b1;
						result_column <= col_q;
						found         <= 1'b1;
						edge_row      <= row_q;
						edge_fraction <= div_quo;
						column_max    <= colmax_q;
						overflow      <= colovf_q;
						rd_left_q     <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[tb/column_threshold_edge_finder_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column threshold edge finder: result checker
// Watches the sample, result and register channels. It keeps its own copy of
// the column buffer and the offset register, works out the edge result that
// each finished column must give, and compares every result word that the
// block emits with the oldest one still waiting.
// ----------------------------------------------------------------------------
module column_threshold_edge_finder_checker #(
	parameter int MAX_ROWS = cte_pkg::MAX_ROWS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [cte_pkg::PIX_W-1:0]   brightness,
	input  logic [cte_pkg::COL_W-1:0]   column_number,
	input  logic                        last_sample,
	input  logic                        result_valid,
	input  logic [cte_pkg::COL_W-1:0]   result_column,
	input  logic                        found,
	input  logic [cte_pkg::ROW_W-1:0]   edge_row,
	input  logic [cte_pkg::FRAC_W-1:0]  edge_fraction,
	input  logic [cte_pkg::PIX_W-1:0]   column_max,
	input  logic                        overflow,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cte_pkg::PADDR_W-1:0] paddr,
	input  logic [cte_pkg::PDATA_W-1:0] pwdata,
	input  logic                        pready,
	output int                          errors,
	output int                          pending
);

	localparam int PIX_W  = cte_pkg::PIX_W;
	localparam int COL_W  = cte_pkg::COL_W;
	localparam int ROW_W  = cte_pkg::ROW_W;
	localparam int FRAC_W = cte_pkg::FRAC_W;
	localparam int OFS_W  = cte_pkg::OFS_W;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic              hit;
		logic [ROW_W-1:0]  row;
		logic [FRAC_W-1:0] frac;
		logic [PIX_W-1:0]  peak;
		logic              dropped;
	} edge_result_t;

	localparam int REPORT_LIMIT = 10;

	// Shadow of the column buffer and the per-column trackers.
	logic [PIX_W-1:0] pixel_mem [MAX_ROWS];
	int               stored_rows;
	logic [PIX_W-1:0] col_peak;
	logic             rows_dropped;
	logic [OFS_W-1:0] offset_reg;

	// Edge results still owed by the block, oldest first.
	edge_result_t     owed_results [$];

	// Scan the stored column bottom-up for the first dark pixel whose three
	// neighbors above reach the threshold. Everything is in 1/16 units.
	function automatic edge_result_t find_edge(input logic [COL_W-1:0] col);
		edge_result_t r;
		int thr, out_val, in_val, up2, up3, o, f;
		r = '0;
		r.column = col;
		r.peak = col_peak;
		r.dropped = rows_dropped;
		thr = int'(col_peak) * 16 - int'(offset_reg);
		o = stored_rows - 1;
		while (o >= cte_pkg::WIN_LEN - 1 && !r.hit) begin
			out_val = int'(pixel_mem[o]) * 16;
			in_val  = int'(pixel_mem[o-1]) * 16;
			up2     = int'(pixel_mem[o-2]) * 16;
			up3     = int'(pixel_mem[o-3]) * 16;
			if (out_val < thr && in_val >= thr && up2 >= thr && up3 >= thr) begin
				f = ((in_val - thr) * 256) / (in_val - out_val);
				if (f > 255)
					f = 255;
				r.hit = 1'b1;
				r.row = ROW_W'(o - 1);
				r.frac = f[FRAC_W-1:0];
			end
			o--;
		end
		return r;
	endfunction

	// Store one accepted sample; the last one of a column closes it.
	task automatic take_sample(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
			input logic last);
		if (stored_rows < MAX_ROWS) begin
			pixel_mem[stored_rows] = pix;
			stored_rows++;
			if (pix > col_peak)
				col_peak = pix;
		end else begin
			rows_dropped = 1'b1;
		end
		if (last) begin
			owed_results.insert(owed_results.size(), find_edge(col));
			stored_rows = 0;
			col_peak = '0;
			rows_dropped = 1'b0;
		end
	endtask

	task automatic flag_failure(input string msg);
		if (errors < REPORT_LIMIT)
			$display("[%0t] %s", $realtime, msg);
		errors++;
	endtask

	// Everything is sampled at the rising edge, before the block updates.
	always @(posedge clk or negedge arst_n) begin
		edge_result_t seen, want;
		if (!arst_n) begin
			stored_rows = 0;
			col_peak = '0;
			rows_dropped = 1'b0;
			offset_reg = '0;
			owed_results.delete();
			errors = 0;
			pending = 0;
		end else begin
			// Register writes; unmapped addresses leave the offset alone.
			if (psel && penable && pwrite && pready &&
					paddr == cte_pkg::ADDR_BRIGHTNESS_OFFSET)
				offset_reg = pwdata[OFS_W-1:0];

			// Result words against the oldest prediction.
			if (result_valid) begin
				seen = '{result_column, found, edge_row, edge_fraction, column_max,
					overflow};
				if (owed_results.size() == 0) begin
					flag_failure($sformatf({"unexpected result word: col=%0d found=%0d",
						" row=%0d frac=%0d max=%0d ovf=%0d"},
						seen.column, seen.hit, seen.row, seen.frac, seen.peak,
						seen.dropped));
				end else begin
					want = owed_results.pop_front();
					if (seen.column !== want.column || seen.hit !== want.hit ||
							seen.row !== want.row || seen.frac !== want.frac ||
							seen.peak !== want.peak || seen.dropped !== want.dropped)
						flag_failure($sformatf({"result mismatch: expected col=%0d found=%0d",
							" row=%0d frac=%0d max=%0d ovf=%0d, got col=%0d found=%0d",
							" row=%0d frac=%0d max=%0d ovf=%0d"},
							want.column, want.hit, want.row, want.frac, want.peak,
							want.dropped, seen.column, seen.hit, seen.row, seen.frac,
							seen.peak, seen.dropped));
				end
			end

			// Accepted sample words feed the shadow buffer.
			if (start && !busy)
				take_sample(brightness, column_number, last_sample);

			pending = owed_results.size();
		end
	end

endmodule

[tb/column_threshold_edge_finder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column threshold edge finder: testbench top
// Feeds image columns into the block under several offset settings: a few
// hand-made columns for the corner cases, then random columns, most of them
// shaped as a bright band over a dark tail, plus one column that overruns the
// buffer. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module column_threshold_edge_finder_tb;

	localparam int PIX_W   = cte_pkg::PIX_W;
	localparam int COL_W   = cte_pkg::COL_W;
	localparam int ROW_W   = cte_pkg::ROW_W;
	localparam int FRAC_W  = cte_pkg::FRAC_W;
	localparam int OFS_W   = cte_pkg::OFS_W;
	localparam int PADDR_W = cte_pkg::PADDR_W;
	localparam int PDATA_W = cte_pkg::PDATA_W;

	localparam int DEPTH        = cte_pkg::MAX_ROWS_DEF;
	localparam int RANDOM_ITEMS = 1600;
	localparam int PHASES       = 6;
	localparam int SHORT_BUDGET = (RANDOM_ITEMS - DEPTH) / PHASES;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES  = 30;
	localparam int STALL_LIMIT  = 4000;
	localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [PIX_W-1:0]     brightness = '0;
	logic [COL_W-1:0]     column_number = '0;
	logic                 last_sample = 1'b0;
	logic                 result_valid;
	logic [COL_W-1:0]     result_column;
	logic                 found;
	logic [ROW_W-1:0]     edge_row;
	logic [FRAC_W-1:0]    edge_fraction;
	logic [PIX_W-1:0]     column_max;
	logic                 overflow;
	logic                 psel = 1'b0;
	logic                 penable = 1'b0;
	logic                 pwrite = 1'b0;
	logic [PADDR_W-1:0]   paddr = '0;
	logic [PDATA_W-1:0]   pwdata = '0;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	int                   errors;
	int                   pending;
	int                   stall_cycles = 0;
	bit                   no_idle = 1'b0;
	logic [PIX_W-1:0]     pixels_q [$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	column_threshold_edge_finder #(.MAX_ROWS(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .brightness(brightness),
		.column_number(column_number), .last_sample(last_sample),
		.result_valid(result_valid), .result_column(result_column), .found(found),
		.edge_row(edge_row), .edge_fraction(edge_fraction), .column_max(column_max),
		.overflow(overflow),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	column_threshold_edge_finder_checker #(.MAX_ROWS(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .brightness(brightness),
		.column_number(column_number), .last_sample(last_sample),
		.result_valid(result_valid), .result_column(result_column), .found(found),
		.edge_row(edge_row), .edge_fraction(edge_fraction), .column_max(column_max),
		.overflow(overflow),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(errors), .pending(pending)
	);

	// Watchdog: ends the run when nothing moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("** column_threshold_edge_finder: FAILED **");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offer one sample word, after a random gap, and wait until it is taken.
	task automatic send_sample(input logic [PIX_W-1:0] pix, input logic [COL_W-1:0] col,
			input logic last);
		int gap;
		gap = 0;
		if (!no_idle)
			while ($urandom_range(0, 99) < 14)
				gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		brightness <= pix;
		column_number <= col;
		last_sample <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Send the column held in pixels_q; the result carries the last column number.
	task automatic send_column(input logic [COL_W-1:0] col);
		int i;
		logic [COL_W-1:0] tag;
		for (i = 0; i < pixels_q.size(); i++) begin
			tag = col;
			if (i < pixels_q.size() - 1 && $urandom_range(0, 9) == 0)
				tag = COL_W'($urandom_range(0, 4095));
			send_sample(pixels_q[i], tag, i == pixels_q.size() - 1);
		end
	endtask

	// Stop offering samples until every predicted result has come out.
	task automatic go_idle();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	// Make sure the block is idle before touching its register.
	task automatic quiesce();
		go_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Setup and access cycle of a register write; upper data bits are noise.
	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [OFS_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= ($urandom() & 32'hFFFF_F000) | value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Fill pixels_q with a random column. Most columns are a bright band over
	// a dark tail; the rest are noise or flat. A bottom edge column puts the
	// dark pixel on the last stored row and fills any dropped rows with noise.
	task automatic build_column(input int len, input bit bottom_edge);
		int kind, dark, bright, top_row, edge_at, i, v;
		pixels_q.delete();
		kind = bottom_edge ? 0 : $urandom_range(0, 99);
		if (kind < 65) begin
			if (bottom_edge) begin
				dark = $urandom_range(0, 20);
				bright = $urandom_range(200, 255);
				top_row = $urandom_range(0, 100);
				edge_at = (len < DEPTH ? len : DEPTH) - 1;
			end else begin
				dark = $urandom_range(0, 150);
				bright = $urandom_range(dark, 255);
				top_row = $urandom_range(0, len / 2);
				edge_at = $urandom_range(top_row, len);
			end
			for (i = 0; i < len; i++) begin
				if (i >= DEPTH)
					v = $urandom_range(0, 255);
				else if (i < top_row || i >= edge_at)
					v = dark + $urandom_range(0, 15);
				else
					v = bright - $urandom_range(0, bright < 12 ? bright : 12);
				pixels_q.insert(pixels_q.size(), v[PIX_W-1:0]);
			end
		end else if (kind < 90) begin
			for (i = 0; i < len; i++)
				pixels_q.insert(pixels_q.size(), PIX_W'($urandom_range(0, 255)));
		end else begin
			v = $urandom_range(0, 255);
			for (i = 0; i < len; i++)
				pixels_q.insert(pixels_q.size(), v[PIX_W-1:0]);
		end
	endtask

	initial begin
		int phase, len, phase_items, columns;
		logic [OFS_W-1:0] ofs;
		bit long_col;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-made columns at the reset offset of zero: short columns,
		// a sharp edge with zero fraction and an all-dark column.
		pixels_q = '{8'd255};
		send_column(12'd4095);
		pixels_q = '{8'd0, 8'd128, 8'd255};
		send_column(12'd0);
		pixels_q = '{8'd255, 8'd255, 8'd255, 8'd0};
		send_column(12'd1);
		pixels_q = '{8'd0, 8'd0, 8'd0, 8'd0};
		send_column(12'd2);

		// A write to an unmapped address must not change the offset; then the
		// largest offset drives the threshold below zero.
		quiesce();
		apb_write(UNMAPPED_ADDR, 12'hFFF);
		pixels_q = '{8'd255, 8'd255, 8'd255, 8'd0};
		send_column(12'd3);
		quiesce();
		apb_write(cte_pkg::ADDR_BRIGHTNESS_OFFSET, 12'hFFF);
		pixels_q = '{8'd255, 8'd255, 8'd255, 8'd0};
		send_column(12'd4);

		// Mid offset: a plain edge with a fraction, then a crossing whose
		// upper neighbors fail before a good one further up.
		quiesce();
		apb_write(cte_pkg::ADDR_BRIGHTNESS_OFFSET, 12'h800);
		pixels_q = '{8'd200, 8'd200, 8'd200, 8'd10};
		send_column(12'd5);
		pixels_q = '{8'd200, 8'd200, 8'd200, 8'd10, 8'd200, 8'd10};
		send_column(12'd6);

		// Random columns, one offset setting per phase. The phase without
		// idle gaps runs the sample channel back to back.
		columns = 0;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       ofs = 12'h400;
				1:       ofs = OFS_W'($urandom_range(0, 4095));
				2:       ofs = 12'hFFF;
				3:       ofs = OFS_W'($urandom_range(0, 12'h7FF));
				4:       ofs = 12'h000;
				default: ofs = OFS_W'($urandom_range(0, 4095));
			endcase
			quiesce();
			apb_write(cte_pkg::ADDR_BRIGHTNESS_OFFSET, ofs);
			no_idle = (phase == 3);
			phase_items = 0;
			while (phase_items < SHORT_BUDGET) begin
				long_col = (phase == 0 && columns == 3);
				if (long_col)
					len = DEPTH + 1;
				else if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, cte_pkg::WIN_LEN - 1);
				else
					len = $urandom_range(cte_pkg::WIN_LEN, 24);
				build_column(len, long_col);
				send_column(COL_W'($urandom_range(0, 4095)));
				if (!long_col)
					phase_items += len;
				columns++;
				if ($urandom_range(0, 99) < 8)
					go_idle();
			end
		end
		no_idle = 1'b0;

		// Drain, give the block time to misbehave, then decide.
		go_idle();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("** column_threshold_edge_finder: PASSED **");
		else
			$display("** column_threshold_edge_finder: FAILED **");
		$finish;
	end

endmodule

[files.f]
src/cte_pkg.sv
src/cte_store.sv
src/cte_div.sv
src/column_threshold_edge_finder.sv
tb/column_threshold_edge_finder_checker.sv
tb/column_threshold_edge_finder_tb.sv
